>>> sv/rti_pkg.sv
// Shared widths, register indexes and word types for the ray/triangle intersection unit.
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

	// Coordinate format: signed Q(CW-FB).FB.
	localparam int CW   = 32;
	localparam int FB   = 16;
	localparam int THRW = 31;
	localparam int IDXW = 4;

	// Exact datapath widths.
	localparam int EW   = CW + 1;            // edges and start-to-corner vector
	localparam int XW   = 2 * EW + 1;        // cross products
	localparam int LW   = (XW + 1) / 2;      // low split of a cross product
	localparam int HW   = XW - LW;           // high split of a cross product
	localparam int DW   = EW + XW + 2;       // dot products
	localparam int KW   = LW;                // chunk width for wide products
	localparam int NK   = (DW + KW - 1) / KW;
	localparam int TW   = KW * NK;
	localparam int NW   = CW + TW;           // |D| * T
	localparam int MDW  = THRW + TW;         // min_dist * det
	localparam int CMPW = MDW + 2;
	localparam int QW   = CW + 2;            // quotient bits kept before saturation
	localparam int SUMW = QW + 3;

	localparam logic signed [SUMW-1:0] SAT_HI =
		signed'({{(SUMW - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
	localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

	// Register indexes.
	localparam logic [IDXW-1:0] REG_START_X  = IDXW'(0);
	localparam logic [IDXW-1:0] REG_START_Y  = IDXW'(1);
	localparam logic [IDXW-1:0] REG_START_Z  = IDXW'(2);
	localparam logic [IDXW-1:0] REG_DIR_X    = IDXW'(3);
	localparam logic [IDXW-1:0] REG_DIR_Y    = IDXW'(4);
	localparam logic [IDXW-1:0] REG_DIR_Z    = IDXW'(5);
	localparam logic [IDXW-1:0] REG_MIN_DET  = IDXW'(6);
	localparam logic [IDXW-1:0] REG_MIN_DIST = IDXW'(7);

	typedef struct packed {
		logic signed [CW-1:0] corner_a_x;
		logic signed [CW-1:0] corner_a_y;
		logic signed [CW-1:0] corner_a_z;
		logic signed [CW-1:0] corner_b_x;
		logic signed [CW-1:0] corner_b_y;
		logic signed [CW-1:0] corner_b_z;
		logic signed [CW-1:0] corner_c_x;
		logic signed [CW-1:0] corner_c_y;
		logic signed [CW-1:0] corner_c_z;
	} tri_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
		logic signed [CW-1:0] hit_z;
	} res_t;

endpackage
`default_nettype wire

>>> sv/ray_triangle_intersect_unit.sv
// Top level of the pipelined ray/triangle intersection unit.
`timescale 1ns / 1ps
`default_nettype none
// Tests one ray against one triangle word per clock. A triangle is taken at every edge where
// start is high; busy is always low. Its result appears on result with done high for one
// cycle; it has ten arithmetic stages plus one restoring division step per quotient bit, 34
// of them. Results come out in order and cannot be held off. The user must write ray and
// thresholds through the cfg port only while no triangle is in flight; this is not enforced.
module ray_triangle_intersect_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rti_pkg::tri_t               triangle,
	output logic                        done,
	output rti_pkg::res_t               result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rti_pkg::IDXW-1:0]    cfg_index,
	input  logic [rti_pkg::CW-1:0]      cfg_data
);
	import rti_pkg::*;

	localparam int LAT = QW + 10;

	// Configuration registers.
	logic signed [CW-1:0]   p_q [3];
	logic signed [CW-1:0]   d_q [3];
	logic [THRW-1:0]        min_det_q;
	logic [THRW-1:0]        min_dist_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q[0]     <= '0;
			p_q[1]     <= '0;
			p_q[2]     <= '0;
			d_q[0]     <= '0;
			d_q[1]     <= '0;
			d_q[2]     <= signed'(CW'(1) << FB);
			min_det_q  <= THRW'(1);
			min_dist_q <= THRW'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_X:  p_q[0]     <= cfg_data;
				REG_START_Y:  p_q[1]     <= cfg_data;
				REG_START_Z:  p_q[2]     <= cfg_data;
				REG_DIR_X:    d_q[0]     <= cfg_data;
				REG_DIR_Y:    d_q[1]     <= cfg_data;
				REG_DIR_Z:    d_q[2]     <= cfg_data;
				REG_MIN_DET:  min_det_q  <= cfg_data[THRW-1:0];
				REG_MIN_DIST: min_dist_q <= cfg_data[THRW-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the arithmetic stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Division pipeline; index 0 is stage 9, index g is g steps later.
	logic                 dv_vld_s  [QW+1];
	logic                 dv_hit_s  [QW+1];
	logic [2:0]           dv_ovf_s  [QW+1];
	logic [DW-1:0]        dv_det_s  [QW+1];
	logic [DW-1:0]        dv_rem_s  [QW+1][3];
	logic [QW-1:0]        dv_nlo_s  [QW+1][3];
	logic [QW-1:0]        dv_quo_s  [QW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int g = 0; g <= QW; g++) dv_vld_s[g] <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			dv_vld_s[0] <= vld_s8;
			for (int g = 0; g < QW; g++) dv_vld_s[g+1] <= dv_vld_s[g];
			done   <= dv_vld_s[QW];
		end
	end

	// Stage 1: edges E1, E2 and start-to-corner vector S.
	logic signed [CW-1:0] ca [3];
	logic signed [CW-1:0] cb [3];
	logic signed [CW-1:0] cc [3];
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], sv_s1 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], sv_s2 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], sv_s3 [3];

	assign ca[0] = triangle.corner_a_x;
	assign ca[1] = triangle.corner_a_y;
	assign ca[2] = triangle.corner_a_z;
	assign cb[0] = triangle.corner_b_x;
	assign cb[1] = triangle.corner_b_y;
	assign cb[2] = triangle.corner_b_z;
	assign cc[0] = triangle.corner_c_x;
	assign cc[1] = triangle.corner_c_y;
	assign cc[2] = triangle.corner_c_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= EW'(cb[i]) - EW'(ca[i]);
			e2_s1[i] <= EW'(cc[i]) - EW'(ca[i]);
			sv_s1[i] <= EW'(p_q[i]) - EW'(ca[i]);
			e1_s2[i] <= e1_s1[i];
			e2_s2[i] <= e2_s1[i];
			sv_s2[i] <= sv_s1[i];
			e1_s3[i] <= e1_s2[i];
			e2_s3[i] <= e2_s2[i];
			sv_s3[i] <= sv_s2[i];
		end
	end

	// Stages 2 and 3: H = D x E2 and Q = S x E1, products first, then differences.
	logic signed [2*EW-1:0] ph_s2 [3][2];
	logic signed [2*EW-1:0] pq_s2 [3][2];
	logic signed [XW-1:0]   h_s3 [3];
	logic signed [XW-1:0]   q_s3 [3];

	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			ph_s2[i][0] <= EW'(d_q[J]) * e2_s1[K];
			ph_s2[i][1] <= EW'(d_q[K]) * e2_s1[J];
			pq_s2[i][0] <= sv_s1[J] * e1_s1[K];
			pq_s2[i][1] <= sv_s1[K] * e1_s1[J];
			h_s3[i]     <= XW'(ph_s2[i][0]) - XW'(ph_s2[i][1]);
			q_s3[i]     <= XW'(pq_s2[i][0]) - XW'(pq_s2[i][1]);
		end
	end

	// Stage 4: split partial products of the four dot products (det, U, V, T).
	logic signed [EW-1:0]    opa [4][3];
	logic signed [XW-1:0]    opb [4][3];
	logic signed [EW+LW:0]   plo_s4 [4][3];
	logic signed [EW+HW-1:0] phi_s4 [4][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opa[0][i] = e1_s3[i];
			opb[0][i] = h_s3[i];
			opa[1][i] = sv_s3[i];
			opb[1][i] = h_s3[i];
			opa[2][i] = EW'(d_q[i]);
			opb[2][i] = q_s3[i];
			opa[3][i] = e2_s3[i];
			opb[3][i] = q_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				plo_s4[k][i] <= opa[k][i] * signed'({1'b0, opb[k][i][LW-1:0]});
				phi_s4[k][i] <= opa[k][i] * signed'(opb[k][i][XW-1:LW]);
			end
		end
	end

	// Stage 5: sum the partial products.
	logic signed [DW-1:0] dot_c [4];
	logic signed [DW-1:0] dot_s5 [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dot_c[k] = '0;
			for (int i = 0; i < 3; i++) begin
				dot_c[k] = dot_c[k] + (DW'(phi_s4[k][i]) <<< LW) + DW'(plo_s4[k][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) dot_s5[k] <= dot_c[k];
	end

	// Stage 6: make the determinant non-negative, negating U, V and T with it.
	logic signed [DW-1:0] det_s6, u_s6, v_s6, t_s6;
	logic                 det_neg;

	assign det_neg = dot_s5[0][DW-1];

	always_ff @(posedge clk) begin
		det_s6 <= det_neg ? -dot_s5[0] : dot_s5[0];
		u_s6   <= det_neg ? -dot_s5[1] : dot_s5[1];
		v_s6   <= det_neg ? -dot_s5[2] : dot_s5[2];
		t_s6   <= det_neg ? -dot_s5[3] : dot_s5[3];
	end

	// Stage 7: determinant and barycentric tests; partial products for the distance
	// threshold and for the numerators |D| * T.
	logic signed [DW-1:0]   lim;
	logic signed [DW:0]     uv_sum;
	logic                   in_tri;
	logic [TW-1:0]          det_w, t_w;
	logic [CW-1:0]          dmag [3];
	logic                   ok_s7;
	logic signed [DW-1:0]   det_s7, t_s7;
	logic [THRW+KW-1:0]     mdp_s7 [NK];
	logic [CW+KW-1:0]       nump_s7 [3][NK];

	assign lim    = signed'(DW'({1'b0, min_det_q, {(2 * FB){1'b0}}}));
	assign uv_sum = (DW + 1)'(u_s6) + (DW + 1)'(v_s6);
	assign in_tri = (det_s6 != '0) && (det_s6 >= lim) && !u_s6[DW-1] && (u_s6 <= det_s6)
		&& !v_s6[DW-1] && (uv_sum <= (DW + 1)'(det_s6));
	assign det_w  = TW'(unsigned'(det_s6));
	assign t_w    = TW'(unsigned'(t_s6));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_q[i][CW-1] ? unsigned'(-d_q[i]) : unsigned'(d_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		ok_s7  <= in_tri;
		det_s7 <= det_s6;
		t_s7   <= t_s6;
		for (int c = 0; c < NK; c++) begin
			mdp_s7[c] <= min_dist_q * det_w[c*KW +: KW];
			for (int i = 0; i < 3; i++) nump_s7[i][c] <= dmag[i] * t_w[c*KW +: KW];
		end
	end

	// Stage 8: sum the chunks.
	logic [MDW-1:0]       md_c;
	logic [NW-1:0]        num_c [3];
	logic                 ok_s8;
	logic signed [DW-1:0] det_s8, t_s8;
	logic [MDW-1:0]       md_s8;
	logic [NW-1:0]        num_s8 [3];

	always_comb begin
		md_c = '0;
		for (int c = 0; c < NK; c++) md_c = md_c + (MDW'(mdp_s7[c]) << (c * KW));
		for (int i = 0; i < 3; i++) begin
			num_c[i] = '0;
			for (int c = 0; c < NK; c++) num_c[i] = num_c[i] + (NW'(nump_s7[i][c]) << (c * KW));
		end
	end

	always_ff @(posedge clk) begin
		ok_s8  <= ok_s7;
		det_s8 <= det_s7;
		t_s8   <= t_s7;
		md_s8  <= md_c;
		for (int i = 0; i < 3; i++) num_s8[i] <= num_c[i];
	end

	// Stage 9: distance test, quotient overflow check and divider setup.
	logic signed [CMPW-1:0] t_scaled, md_cmp;
	logic                   far_enough;

	assign t_scaled   = CMPW'(t_s8) <<< FB;
	assign md_cmp     = signed'({2'b00, md_s8});
	assign far_enough = t_scaled > md_cmp;

	always_ff @(posedge clk) begin
		dv_hit_s[0] <= ok_s8 && far_enough;
		dv_det_s[0] <= unsigned'(det_s8);
		for (int i = 0; i < 3; i++) begin
			dv_ovf_s[0][i] <= NW'(num_s8[i] >> QW) >= NW'(unsigned'(det_s8));
			dv_rem_s[0][i] <= DW'(num_s8[i] >> QW);
			dv_nlo_s[0][i] <= num_s8[i][QW-1:0];
			dv_quo_s[0][i] <= '0;
		end
	end

	// Restoring division of |D| * T by det, one quotient bit per stage.
	for (genvar g = 0; g < QW; g++) begin : g_div
		logic [DW-1:0] rs   [3];
		logic          take [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rs[i]   = {dv_rem_s[g][i][DW-2:0], dv_nlo_s[g][i][QW-1-g]};
				take[i] = rs[i] >= dv_det_s[g];
			end
		end
		always_ff @(posedge clk) begin
			dv_hit_s[g+1] <= dv_hit_s[g];
			dv_ovf_s[g+1] <= dv_ovf_s[g];
			dv_det_s[g+1] <= dv_det_s[g];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[g+1][i] <= take[i] ? rs[i] - dv_det_s[g] : rs[i];
				dv_nlo_s[g+1][i] <= dv_nlo_s[g][i];
				dv_quo_s[g+1][i] <= {dv_quo_s[g][i][QW-2:0], take[i]};
			end
		end
	end

	// Output stage: signed offset, add to the start point, saturate, zero on a miss.
	logic [QW:0]            off_mag [3];
	logic signed [QW+1:0]   off     [3];
	logic signed [SUMW-1:0] pt      [3];
	logic signed [CW-1:0]   pt_sat  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_mag[i] = dv_ovf_s[QW][i] ? {1'b1, {QW{1'b0}}} : {1'b0, dv_quo_s[QW][i]};
			off[i]     = d_q[i][CW-1] ? -signed'({1'b0, off_mag[i]}) : signed'({1'b0, off_mag[i]});
			pt[i]      = SUMW'(p_q[i]) + SUMW'(off[i]);
			if (!dv_hit_s[QW]) begin
				pt_sat[i] = '0;
			end else if (pt[i] > SAT_HI) begin
				pt_sat[i] = SAT_HI[CW-1:0];
			end else if (pt[i] < SAT_LO) begin
				pt_sat[i] = SAT_LO[CW-1:0];
			end else begin
				pt_sat[i] = pt[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result.hit   <= dv_hit_s[QW];
		result.hit_x <= pt_sat[0];
		result.hit_y <= pt_sat[1];
		result.hit_z <= pt_sat[2];
	end

	// Every taken triangle gives exactly one word, and done is never high otherwise.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n, LAT))
		else $error("result strobe does not match the pipeline latency");

	// A miss reports the zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.hit_x == '0 && result.hit_y == '0
			&& result.hit_z == '0))
		else $error("miss word carries a nonzero point");

	// The configuration port never stalls a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the ray/triangle intersection unit.
`timescale 1ns / 1ps
module tb_top;
	import rti_pkg::*;

	localparam int WIDE = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [IDXW-1:0] REG_UNUSED = IDXW'(15);
	localparam logic [IDXW-1:0] REG_UNUSED_LOW = IDXW'(8);
	localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

	typedef logic signed [WIDE-1:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	tri_t triangle = '0;
	logic done;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDXW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	// Shadow copy of the ray and thresholds.
	logic signed [CW-1:0] ray_start [3];
	logic signed [CW-1:0] ray_dir [3];
	logic [THRW-1:0] det_floor;
	logic [THRW-1:0] dist_floor;

	res_t pending_hits [$];
	int error_count = 0;
	int cycle_count = 0;
	int sent_count = 0;
	int hit_count = 0;
	int checked_count = 0;
	bit steady_run = 1'b0;

	ray_triangle_intersect_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .triangle(triangle),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic wide_t dot3(input wide_t a [3], input wide_t b [3]);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	task automatic cross3(input wide_t a [3], input wide_t b [3], output wide_t r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endtask

	// Exact Moller-Trumbore test with the point truncated toward zero and saturated.
	task automatic predict_hit(input tri_t tr, output res_t res);
		wide_t p [3], d [3], a [3], b [3], c [3], e1 [3], e2 [3], s [3], h [3], q [3];
		wide_t det, u, v, t, off, sum;
		res = '0;
		a[0] = tr.corner_a_x; a[1] = tr.corner_a_y; a[2] = tr.corner_a_z;
		b[0] = tr.corner_b_x; b[1] = tr.corner_b_y; b[2] = tr.corner_b_z;
		c[0] = tr.corner_c_x; c[1] = tr.corner_c_y; c[2] = tr.corner_c_z;
		for (int i = 0; i < 3; i++) begin
			p[i] = ray_start[i];
			d[i] = ray_dir[i];
			e1[i] = b[i] - a[i];
			e2[i] = c[i] - a[i];
			s[i] = p[i] - a[i];
		end
		cross3(d, e2, h);
		det = dot3(e1, h);
		u = dot3(s, h);
		cross3(s, e1, q);
		v = dot3(d, q);
		t = dot3(e2, q);
		if (det < 0) begin
			det = -det; u = -u; v = -v; t = -t;
		end
		if (det == 0 || det < (wide_t'(det_floor) <<< (2 * FB))) return;
		if (u < 0 || u > det || v < 0 || u + v > det) return;
		if ((t <<< FB) <= wide_t'(dist_floor) * det) return;
		res.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			off = (d[i] * t) / det;
			sum = p[i] + off;
			if (sum > wide_t'(CMAX)) sum = wide_t'(CMAX);
			if (sum < wide_t'(CMIN)) sum = wide_t'(CMIN);
			case (i)
				0: res.hit_x = sum[CW-1:0];
				1: res.hit_y = sum[CW-1:0];
				default: res.hit_z = sum[CW-1:0];
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	// Result checker: every done word is matched against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (done) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected result", result.hit_x, '0);
			end else begin
				want = pending_hits.pop_front();
				checked_count++;
				if (want.hit) hit_count++;
				if (result.hit !== want.hit)
					report_mismatch("hit", CW'(result.hit), CW'(want.hit));
				if (result.hit_x !== want.hit_x) report_mismatch("hit_x", result.hit_x, want.hit_x);
				if (result.hit_y !== want.hit_y) report_mismatch("hit_y", result.hit_y, want.hit_y);
				if (result.hit_z !== want.hit_z) report_mismatch("hit_z", result.hit_z, want.hit_z);
			end
		end
	end

	// Send one triangle word, with a random gap before it unless in a steady run.
	// Start stays high afterwards so the next word can follow with no gap.
	task automatic send_triangle(input tri_t tr);
		res_t want;
		while (!steady_run && $urandom_range(99) < 16) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		triangle <= tr;
		#0;
		while (busy) @(negedge clk);
		predict_hit(tr, want);
		pending_hits.push_back(want);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write one register; the shadow copy follows on acceptance.
	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		#0;
		while (!cfg_ready) @(negedge clk);
		case (idx)
			REG_START_X: ray_start[0] = val;
			REG_START_Y: ray_start[1] = val;
			REG_START_Z: ray_start[2] = val;
			REG_DIR_X: ray_dir[0] = val;
			REG_DIR_Y: ray_dir[1] = val;
			REG_DIR_Z: ray_dir[2] = val;
			REG_MIN_DET: det_floor = val[THRW-1:0];
			REG_MIN_DIST: dist_floor = val[THRW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_ray(input logic [CW-1:0] sx, sy, sz, dx, dy, dz,
			input logic [CW-1:0] mdet, mdist);
		wait_idle();
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_MIN_DET, mdet);
		write_reg(REG_MIN_DIST, mdist);
	endtask

	function automatic tri_t make_tri(input logic signed [CW-1:0] ax, ay, az, bx, by, bz,
			cx, cy, cz);
		tri_t tr;
		tr.corner_a_x = ax; tr.corner_a_y = ay; tr.corner_a_z = az;
		tr.corner_b_x = bx; tr.corner_b_y = by; tr.corner_b_z = bz;
		tr.corner_c_x = cx; tr.corner_c_y = cy; tr.corner_c_z = cz;
		return tr;
	endfunction

	function automatic logic signed [CW-1:0] rand_small(input int span);
		return $signed(CW'($urandom_range(0, 2 * span))) - span;
	endfunction

	// Triangle built around a point on the ray, so most of these are hits.
	function automatic tri_t aimed_tri();
		logic signed [63:0] k, x, bo, co, ao;
		logic signed [CW-1:0] av [3], bv [3], cv [3];
		k = $signed(64'($urandom_range(1, 4 * 65536)));
		if ($urandom_range(9) == 0) k = -k;
		for (int i = 0; i < 3; i++) begin
			x = 64'(ray_start[i]) + ((64'(ray_dir[i]) * k) >>> FB);
			bo = x + rand_small(1 << 20);
			co = x + rand_small(1 << 20);
			ao = 2 * x - (bo >>> 1) - (co >>> 1);
			bv[i] = bo[CW-1:0];
			cv[i] = co[CW-1:0];
			av[i] = ao[CW-1:0];
		end
		return make_tri(av[0], av[1], av[2], bv[0], bv[1], bv[2], cv[0], cv[1], cv[2]);
	endfunction

	function automatic tri_t noise_tri();
		tri_t tr;
		for (int i = 0; i < 9; i++) tr[i*CW +: CW] = $urandom();
		return tr;
	endfunction

	task automatic random_triangles(input int count);
		for (int n = 0; n < count; n++) begin
			steady_run = (n >= count / 3 && n < count / 2);
			if ($urandom_range(99) < 65) send_triangle(aimed_tri());
			else send_triangle(noise_tri());
		end
		steady_run = 1'b0;
	endtask

	// Hand-picked cases on the reset ray (origin, along +z).
	task automatic test_directed();
		send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE));
		// Corner exactly on the ray and the ray through an edge.
		send_triangle(make_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
		send_triangle(make_tri(-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
		// Just outside the triangle.
		send_triangle(make_tri(1, 1, ONE, ONE, 1, ONE, 1, ONE, ONE));
		// Degenerate triangle, zero determinant.
		send_triangle(make_tri(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE));
		// Plane containing the ray direction.
		send_triangle(make_tri(-ONE, 0, 0, ONE, 0, 0, 0, 0, ONE));
		// Behind the start and at zero distance.
		send_triangle(make_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE));
		send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
		// Distance right at and just above the threshold.
		send_triangle(make_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1));
		send_triangle(make_tri(-ONE, -ONE, 2, ONE, -ONE, 2, 0, ONE, 2));
		// Field extremes.
		send_triangle(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_triangle(make_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, 0, CMAX, CMAX));
		send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, 0, CMAX, CMIN));
		send_triangle(make_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, 0, CMAX, 0));
		send_triangle(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_triangle('0);
	endtask

	// Thresholds at zero and at their top, plus ignored register indexes.
	task automatic test_thresholds();
		write_ray(0, 0, 0, 0, 0, ONE, 0, 0);
		write_reg(REG_UNUSED, CMAX);
		write_reg(REG_UNUSED_LOW, CMIN);
		send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
		send_triangle(make_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1));
		send_triangle(make_tri(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
		random_triangles(60);
		write_ray(0, 0, 0, 0, 0, ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE));
		random_triangles(60);
	endtask

	task automatic test_random_rays();
		for (int phase = 0; phase < 6; phase++) begin
			write_ray(rand_small(1 << 22), rand_small(1 << 22), rand_small(1 << 22),
				rand_small(1 << 18), rand_small(1 << 18), rand_small(1 << 18),
				$urandom_range(0, 64), $urandom_range(0, 4096));
			random_triangles(110);
		end
	endtask

	// Ray registers at the ends of their range, then a diagonal ray from the origin.
	task automatic test_extreme_rays();
		write_ray(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 1, 1);
		random_triangles(80);
		write_ray(CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, 0, 0);
		random_triangles(80);
		write_ray(0, 0, 0, ONE, ONE, ONE, 1, 1);
		random_triangles(60);
	endtask

	initial begin
		ray_start = '{0, 0, 0};
		ray_dir = '{0, 0, ONE};
		det_floor = THRW'(1);
		dist_floor = THRW'(1);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_thresholds();
		test_random_rays();
		test_extreme_rays();
		wait_idle();
		$display("sent %0d triangles over several ray and threshold settings", sent_count);
		$display("checked %0d results, %0d of them hits", checked_count, hit_count);
		if (error_count == 0 && pending_hits.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
